// File: rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// Greedy match selector package
// Beat types, candidate entry layout, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_CEIL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_REUSE = 2'd3;

    localparam logic signed [15:0] TOUCH_LIMIT_RST = 16'sd8192;
    localparam logic signed [15:0] SCORE_FLOOR_RST = 16'sd0;
    localparam logic signed [15:0] SCORE_CEIL_RST = 16'sd4096;

    localparam logic PASS_TOUCH = 1'b0;
    localparam logic PASS_SCORE = 1'b1;

    typedef struct packed {
        logic [7:0]         object_id;
        logic [7:0]         flash_tag;
        logic               has_touch;
        logic signed [15:0] touch_metric;
        logic signed [15:0] match_score;
        logic               last_candidate;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]         picked_index;
        logic [7:0]         picked_object;
        logic [7:0]         picked_flash;
        logic signed [15:0] picked_score;
        logic               picked_pass;
        logic               none_picked;
        logic               overflowed;
        logic               last_result;
    } out_beat_t;

    // one stored candidate, 49 bits
    typedef struct packed {
        logic [7:0]         obj;
        logic [7:0]         fl;
        logic               touch;
        logic signed [15:0] tscore;
        logic signed [15:0] mscore;
    } cand_t;

    localparam int CAND_W = $bits(cand_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_SCAN,
        ST_USED_RD,
        ST_USED_CHK,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/gms_ram.sv
// ----------------------------------------------------------------------------
// Greedy match selector RAM
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/greedy_match_selector_top.sv
// ----------------------------------------------------------------------------
// Greedy match selector
// Loads candidate matches, then picks them greedily in a touch pass and a
// score pass, emitting each accepted match as one output beat.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one candidate per beat, one beat a cycle while loading;
//                 the beat with last_candidate set starts selection.
//   out channel : accepted matches in acceptance order, last_result on the
//                 final beat; a run with no match gives one none_picked beat.
//   cfg port    : plain writes; write only while the block is idle.
// Flow: each pass repeatedly scans the candidate RAM, reading every stored
//   word in turn through its single read port and then checking for the end,
//   to find the next candidate in order, then looks that candidate up in the
//   used-id RAMs (ST_USED_RD, then ST_USED_CHK). Once the output is free, a
//   flush hands out the final beat, and a sweep of all ID_COUNT entries of
//   the used-id RAMs runs before the next candidate is taken.
// Reset: the same sweep clears the used-id RAMs; in_ready is low
//   throughout. The state, count and valid registers return to reset values.
// Stalls: one result sits in the output register and one more in a pending
//   slot; when both are full selection holds until out_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_match_selector_top #(
    parameter int MAX_CANDIDATES = 64,
    parameter int ID_COUNT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire gms_pkg::in_beat_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output gms_pkg::out_beat_t                       out_data,
    input  wire logic                                cfg_we,
    input  wire logic [gms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import gms_pkg::*;

    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int ID_W = $clog2(ID_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] touch_limit_reg;
    logic signed [15:0] score_floor_reg;
    logic signed [15:0] score_ceil_reg;
    logic               flash_reuse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_limit_reg <= TOUCH_LIMIT_RST;
            score_floor_reg <= SCORE_FLOOR_RST;
            score_ceil_reg  <= SCORE_CEIL_RST;
            flash_reuse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_LIMIT: touch_limit_reg <= cfg_data;
                CFG_SCORE_FLOOR: score_floor_reg <= cfg_data;
                CFG_SCORE_CEIL:  score_ceil_reg  <= cfg_data;
                CFG_FLASH_REUSE: flash_reuse_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // id to used-table address: constant table of id modulo ID_COUNT
    logic [ID_W-1:0] id_map [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_id_map
        assign id_map[g] = ID_W'(g % ID_COUNT);
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;
    logic               pass_reg;
    logic               first_reg;
    logic [CNT_W-1:0]   scan_addr_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               best_vld_reg;
    logic signed [16:0] best_key_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [7:0]         best_obj_reg;
    logic [7:0]         best_fl_reg;
    logic signed [15:0] best_score_reg;
    logic signed [16:0] last_key_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [ID_W-1:0]    clr_addr_reg;
    logic               pend_vld_reg;
    out_beat_t          pend_reg;
    logic               out_vld_reg;
    out_beat_t          out_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic       store_rd_en;
    cand_t      store_rd_data;
    logic       store_wr_en;
    cand_t      store_wr_data;
    logic       used_rd_en;
    logic       obj_used;
    logic       fl_used;
    logic       used_wr_en;
    logic [ID_W-1:0] obj_wr_addr;
    logic [ID_W-1:0] fl_wr_addr;
    logic       used_wr_data;

    gms_ram #(
        .WIDTH (CAND_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_store (
        .clk     (clk),
        .rd_en   (store_rd_en),
        .rd_addr (scan_addr_reg[IDX_W-1:0]),
        .rd_data (store_rd_data),
        .wr_en   (store_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (store_wr_data)
    );

    gms_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_obj_used (
        .clk     (clk),
        .rd_en   (used_rd_en),
        .rd_addr (id_map[best_obj_reg]),
        .rd_data (obj_used),
        .wr_en   (used_wr_en),
        .wr_addr (obj_wr_addr),
        .wr_data (used_wr_data)
    );

    gms_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_fl_used (
        .clk     (clk),
        .rd_en   (used_rd_en),
        .rd_addr (id_map[best_fl_reg]),
        .rd_data (fl_used),
        .wr_en   (used_wr_en),
        .wr_addr (fl_wr_addr),
        .wr_data (used_wr_data)
    );

    // ------------------------------------------------------------------
    // Ordering key of the word coming out of the store
    // ------------------------------------------------------------------
    // Both passes become an ascending key: the touch pass uses the absolute
    // touch score, the score pass the negated clamped match score.
    logic signed [16:0] t_ext;
    logic signed [16:0] t_abs;
    logic signed [15:0] m_clamp;
    logic signed [16:0] cur_key;
    logic               cur_elig;
    logic               after_last;
    logic               beats_best;

    always_comb
    begin
        t_ext   = {store_rd_data.tscore[15], store_rd_data.tscore};
        t_abs   = store_rd_data.tscore < 0 ? -t_ext : t_ext;
        m_clamp = store_rd_data.mscore < score_ceil_reg ? store_rd_data.mscore
                                                        : score_ceil_reg;
        if (pass_reg == PASS_SCORE)
        begin
            cur_key  = -{m_clamp[15], m_clamp};
            cur_elig = store_rd_data.mscore >= score_floor_reg;
        end
        else
        begin
            cur_key  = t_abs;
            cur_elig = store_rd_data.touch
                       && (t_abs <= $signed({touch_limit_reg[15], touch_limit_reg}));
        end
        after_last = first_reg || (cur_key > last_key_reg)
                     || ((cur_key == last_key_reg) && (rd_idx_reg > last_idx_reg));
        // scan runs in load order, so an equal key never displaces the best
        beats_best = !best_vld_reg || (cur_key < best_key_reg);
    end

    // ------------------------------------------------------------------
    // Handshakes and next state
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_free;
    logic scan_done;
    logic pick_ok;
    logic pick_stall;
    logic out_load;

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign scan_done = (scan_addr_reg == count_reg) && !rd_vld_reg;
    assign pick_ok   = !obj_used && (flash_reuse_reg || !fl_used);
    assign pick_stall = pick_ok && pend_vld_reg && !out_free;
    // the output register takes a beat on a pick with one held, or on flush
    assign out_load  = ((state_reg == ST_USED_CHK) && pick_ok && !pick_stall
                        && pend_vld_reg)
                       || ((state_reg == ST_FLUSH) && out_free);

    always_comb
    begin
        state_next    = state_reg;
        store_rd_en   = 1'b0;
        store_wr_en   = 1'b0;
        store_wr_data = '{obj: in_data.object_id, fl: in_data.flash_tag,
                          touch: in_data.has_touch, tscore: in_data.touch_metric,
                          mscore: in_data.match_score};
        used_rd_en    = 1'b0;
        used_wr_en    = 1'b0;
        used_wr_data  = 1'b0;
        obj_wr_addr   = clr_addr_reg;
        fl_wr_addr    = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                used_wr_en = 1'b1;
                if (clr_addr_reg == ID_W'(ID_COUNT - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                store_wr_en = in_fire && (count_reg < CNT_W'(MAX_CANDIDATES));
                if (in_fire && in_data.last_candidate)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                store_rd_en = scan_addr_reg < count_reg;
                if (scan_done)
                begin
                    if (best_vld_reg)
                    begin
                        state_next = ST_USED_RD;
                    end
                    else if (pass_reg == PASS_SCORE)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_USED_RD:
            begin
                used_rd_en = 1'b1;
                state_next = ST_USED_CHK;
            end
            ST_USED_CHK:
            begin
                obj_wr_addr  = id_map[best_obj_reg];
                fl_wr_addr   = id_map[best_fl_reg];
                used_wr_data = 1'b1;
                used_wr_en   = pick_ok && !pick_stall;
                if (!pick_stall)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pass_reg      <= PASS_TOUCH;
            first_reg     <= 1'b1;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            // load a new output beat, else drop the current one once taken
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            rd_vld_reg <= store_rd_en;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    clr_addr_reg <= '0;
                    if (in_fire)
                    begin
                        if (store_wr_en)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    pass_reg      <= PASS_TOUCH;
                    first_reg     <= 1'b1;
                    scan_addr_reg <= '0;
                    best_vld_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (store_rd_en)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                        rd_idx_reg    <= scan_addr_reg[IDX_W-1:0];
                    end
                    if (rd_vld_reg && cur_elig && after_last && beats_best)
                    begin
                        best_vld_reg   <= 1'b1;
                        best_key_reg   <= cur_key;
                        best_idx_reg   <= rd_idx_reg;
                        best_obj_reg   <= store_rd_data.obj;
                        best_fl_reg    <= store_rd_data.fl;
                        best_score_reg <= store_rd_data.mscore;
                    end
                    if (scan_done && !best_vld_reg && pass_reg == PASS_TOUCH)
                    begin
                        // advance to the score pass
                        pass_reg      <= PASS_SCORE;
                        first_reg     <= 1'b1;
                        scan_addr_reg <= '0;
                    end
                end
                ST_USED_RD:
                begin
                    last_key_reg <= best_key_reg;
                    last_idx_reg <= best_idx_reg;
                    first_reg    <= 1'b0;
                end
                ST_USED_CHK:
                begin
                    if (!pick_stall)
                    begin
                        scan_addr_reg <= '0;
                        best_vld_reg  <= 1'b0;
                    end
                    if (pick_ok && !pick_stall)
                    begin
                        // move the held result out and hold the new one
                        if (pend_vld_reg)
                        begin
                            out_reg <= pend_reg;
                        end
                        pend_vld_reg <= 1'b1;
                        pend_reg     <= '{picked_index: 6'(best_idx_reg),
                                          picked_object: best_obj_reg,
                                          picked_flash: best_fl_reg,
                                          picked_score: best_score_reg,
                                          picked_pass: pass_reg,
                                          none_picked: 1'b0,
                                          overflowed: ovf_reg,
                                          last_result: 1'b0};
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_reg <= '{picked_index: pend_reg.picked_index,
                                         picked_object: pend_reg.picked_object,
                                         picked_flash: pend_reg.picked_flash,
                                         picked_score: pend_reg.picked_score,
                                         picked_pass: pend_reg.picked_pass,
                                         none_picked: pend_reg.none_picked,
                                         overflowed: pend_reg.overflowed,
                                         last_result: 1'b1};
                        end
                        else
                        begin
                            out_reg <= '{picked_index: '0,
                                         picked_object: '0,
                                         picked_flash: '0,
                                         picked_score: '0,
                                         picked_pass: 1'b0,
                                         none_picked: 1'b1,
                                         overflowed: ovf_reg,
                                         last_result: 1'b1};
                        end
                        pend_vld_reg <= 1'b0;
                        count_reg    <= '0;
                        ovf_reg      <= 1'b0;
                        clr_addr_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: dv/greedy_match_selector_top_tb.sv
// ----------------------------------------------------------------------------
// Greedy match selector testbench
// Streams runs of candidate matches into the block under several register
// settings, predicts the accepted matches of each run with a behavioural
// copy of the two-pass greedy selection, and checks every output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_match_selector_top_tb;

    import gms_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int IDS         = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 400;   // flush sweep of the used-id RAMs plus margin
    localparam int HOLD_CYCLES = 3000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    logic      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TOUCH_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    greedy_match_selector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow registers, written alongside each configuration write
    logic signed [15:0] sh_touch_limit = TOUCH_LIMIT_RST;
    logic signed [15:0] sh_floor = SCORE_FLOOR_RST;
    logic signed [15:0] sh_ceiling = SCORE_CEIL_RST;
    logic               sh_reuse = 1'b0;

    // Predictor state: stored candidates of the current run
    cand_t     loaded [CAPACITY];
    int        loaded_count = 0;
    bit        dropped = 1'b0;

    in_beat_t  pending_cands [$];
    out_beat_t expected_picks [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Take one candidate beat; on the last one run both greedy passes and
    // queue the accepted matches in acceptance order.
    task automatic take_candidate(input in_beat_t b);
        int        order [$];
        int        keys [CAPACITY];
        bit        obj_taken [IDS];
        bit        fl_taken [IDS];
        int        j;
        int        key;
        int        picks;
        bit        ok;
        out_beat_t r;
        if (loaded_count < CAPACITY)
        begin
            loaded[loaded_count] = '{b.object_id, b.flash_tag, b.has_touch,
                                     b.touch_metric, b.match_score};
            loaded_count++;
        end
        else
            dropped = 1'b1;
        if (!b.last_candidate)
            return;
        picks = 0;
        for (int p = 0; p < 2; p++)
        begin
            order.delete();
            for (int i = 0; i < loaded_count; i++)
            begin
                if (p == 0)
                begin
                    key = int'(loaded[i].tscore);
                    if (key < 0)
                        key = -key;
                    ok = loaded[i].touch && key <= int'(sh_touch_limit);
                end
                else
                begin
                    key = int'(loaded[i].mscore);
                    ok = key >= int'(sh_floor);
                    if (key > int'(sh_ceiling))
                        key = int'(sh_ceiling);
                end
                if (!ok)
                    continue;
                keys[i] = key;
                // stable insert: ascending for the touch pass, descending for scores
                j = order.size();
                while (j > 0 && ((p == 0) ? (key < keys[order[j-1]])
                                          : (key > keys[order[j-1]])))
                    j--;
                order.insert(j, i);
            end
            foreach (order[n])
            begin
                cand_t c;
                c = loaded[order[n]];
                if (obj_taken[c.obj] || (!sh_reuse && fl_taken[c.fl]))
                    continue;
                obj_taken[c.obj] = 1'b1;
                fl_taken[c.fl] = 1'b1;
                r = '0;
                r.picked_index  = order[n][5:0];
                r.picked_object = c.obj;
                r.picked_flash  = c.fl;
                r.picked_score  = c.mscore;
                r.picked_pass   = (p == 0) ? PASS_TOUCH : PASS_SCORE;
                r.overflowed    = dropped;
                expected_picks = {expected_picks, r};
                picks++;
            end
        end
        if (picks == 0)
        begin
            r = '0;
            r.none_picked = 1'b1;
            r.overflowed  = dropped;
            r.last_result = 1'b1;
            expected_picks = {expected_picks, r};
        end
        else
            expected_picks[expected_picks.size()-1].last_result = 1'b1;
        loaded_count = 0;
        dropped = 1'b0;
    endtask

    // Driver: advance to the next pending candidate once the current beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_candidate(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_cands.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data  <= pending_cands.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off: once, with plenty of matches still to come, hold off
    // so the result slots fill and selection backs up into the input
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && out_valid && expected_picks.size() >= 3)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: check each output beat against the oldest expected match
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("unexpected output beat %p", out_data);
                    errors++;
                end
                else
                begin
                    out_beat_t e;
                    e = expected_picks.pop_front();
                    if (out_data.picked_index !== e.picked_index)
                    begin
                        $error("picked_index exp %0d got %0d", e.picked_index,
                               out_data.picked_index);
                        errors++;
                    end
                    if (out_data.picked_object !== e.picked_object)
                    begin
                        $error("picked_object exp %0d got %0d", e.picked_object,
                               out_data.picked_object);
                        errors++;
                    end
                    if (out_data.picked_flash !== e.picked_flash)
                    begin
                        $error("picked_flash exp %0d got %0d", e.picked_flash,
                               out_data.picked_flash);
                        errors++;
                    end
                    if (out_data.picked_score !== e.picked_score)
                    begin
                        $error("picked_score exp %0d got %0d", e.picked_score,
                               out_data.picked_score);
                        errors++;
                    end
                    if (out_data.picked_pass !== e.picked_pass)
                    begin
                        $error("picked_pass exp %0d got %0d", e.picked_pass,
                               out_data.picked_pass);
                        errors++;
                    end
                    if (out_data.none_picked !== e.none_picked)
                    begin
                        $error("none_picked exp %0d got %0d", e.none_picked,
                               out_data.none_picked);
                        errors++;
                    end
                    if (out_data.overflowed !== e.overflowed)
                    begin
                        $error("overflowed exp %0d got %0d", e.overflowed,
                               out_data.overflowed);
                        errors++;
                    end
                    if (out_data.last_result !== e.last_result)
                    begin
                        $error("last_result exp %0d got %0d", e.last_result,
                               out_data.last_result);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[greedy_match_selector_top] ERROR");
            $finish;
        end
    end

    function automatic in_beat_t cand(input int obj, input int fl, input bit touch,
                                      input int ts, input int ms, input bit last);
        in_beat_t b;
        b.object_id      = obj[7:0];
        b.flash_tag      = fl[7:0];
        b.has_touch      = touch;
        b.touch_metric   = ts[15:0];
        b.match_score    = ms[15:0];
        b.last_candidate = last;
        return b;
    endfunction

    // Score biased to the extremes and to the register thresholds
    function automatic int pick_score(input logic signed [15:0] near);
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return int'(near) + $urandom_range(0, 2) - 1;
            3: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 24000)) - 12000;
        endcase
    endfunction

    function automatic in_beat_t random_cand(input bit last);
        int obj;
        int fl;
        obj = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        fl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        return cand(obj, fl, $urandom_range(0, 1), pick_score(sh_touch_limit),
                    pick_score($urandom_range(0, 1) ? sh_floor : sh_ceiling), last);
    endfunction

    // Append one candidate to the driver's queue
    task automatic queue_cand(input in_beat_t b);
        pending_cands = {pending_cands, b};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        case (idx)
            CFG_TOUCH_LIMIT: sh_touch_limit = val[15:0];
            CFG_SCORE_FLOOR: sh_floor = val[15:0];
            CFG_SCORE_CEIL:  sh_ceiling = val[15:0];
            default:         sh_reuse = val[0];
        endcase
    endtask

    task automatic set_regs(input int lim, input int flo, input int ceil_v, input int reuse);
        write_reg(CFG_TOUCH_LIMIT, lim);
        write_reg(CFG_SCORE_FLOOR, flo);
        write_reg(CFG_SCORE_CEIL, ceil_v);
        write_reg(CFG_FLASH_REUSE, reuse);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cands.size() > 0 || in_valid || expected_picks.size() > 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int fed;
        int len;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // let the reset sweep of the used-id RAMs finish
        repeat (SETTLE) @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: set_regs(32767, -32768, 32767, 1);
                2: set_regs(-1, 4096, -32768, 0);        // ceiling below floor
                3: set_regs(-32768, 32767, 0, 1);
                4: set_regs(int'($urandom_range(0, 16384)),
                            int'($urandom_range(0, 8192)) - 4096,
                            int'($urandom_range(0, 8192)) - 2048, $urandom_range(0, 1));
                5: set_regs(8192, 0, 4096, 0);
                default: ;
            endcase
            @(negedge clk);
            send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 45 : 0;
            recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 36 : 0;
            if (ph == 0)
            begin
                // nothing acceptable: one empty-result beat
                queue_cand(cand(0, 0, 0, 0, -1, 1));
                // extremes, flash conflict, score equal to floor, clamped tie
                queue_cand(cand(255, 255, 1, -32768, 32767, 0));
                queue_cand(cand(1, 1, 1, 8192, -32768, 0));
                queue_cand(cand(2, 1, 1, -8192, 0, 0));
                queue_cand(cand(3, 3, 0, 32767, 0, 0));
                queue_cand(cand(4, 4, 1, 100, 4096, 0));
                queue_cand(cand(5, 5, 0, -100, 5000, 1));
                // many distinct matches: used for the long receiver hold-off
                for (int i = 0; i < 8; i++)
                    queue_cand(cand(16 + i, 32 + i, i[0], 50 * i, 1000, i == 7));
            end
            fed = 0;
            while (fed < 56)
            begin
                if (ph == 1 && fed == 0)
                    len = CAPACITY + 6;               // overflow the store
                else if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(16, CAPACITY);
                else
                    len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    queue_cand(random_cand(i == len - 1));
                fed += len;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("[greedy_match_selector_top] OK");
        else
            $display("[greedy_match_selector_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
